// ===== sv/vap_pkg.sv =====
// shared constants and the arctangent table for the vertex angle pipeline
package vap_pkg;

   localparam int COORD_BITS_DEF      = 24;
   localparam int ANGLE_FRAC_BITS_DEF = 16;
   localparam int Q                   = 30;
   localparam int ANGLE_W             = 18;
   localparam int CORDIC_W            = 34;

   localparam logic signed [CORDIC_W-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [CORDIC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

   function automatic logic signed [CORDIC_W-1:0] atan_q30(input int i);
      logic signed [CORDIC_W-1:0] r;
      case (i)
         0: r = 34'sd843314857;
         1: r = 34'sd497837829;
         2: r = 34'sd263043837;
         3: r = 34'sd133525159;
         4: r = 34'sd67021687;
         5: r = 34'sd33543516;
         6: r = 34'sd16775851;
         7: r = 34'sd8388437;
         8: r = 34'sd4194283;
         9: r = 34'sd2097149;
         default: r = CORDIC_W'(1) << (Q - i);
      endcase
      return r;
   endfunction

endpackage

// ===== sv/vap_sqrt.sv =====
// pipelined integer square root, one result bit per stage
module vap_sqrt #(
   parameter int IN_W = 62
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [IN_W-1:0]          radicand,
   output logic [(IN_W+1)/2-1:0]    root
);
   localparam int RW = (IN_W + 1) / 2;
   localparam int CW = RW + 3;

   logic [2*RW-1:0] rad_ff  [RW];
   logic [CW-1:0]   rem_ff  [RW];
   logic [RW-1:0]   root_ff [RW];

   for (genvar j = 0; j < RW; j++) begin : g_step
      logic [2*RW-1:0] rad_p;
      logic [CW-1:0]   rem_p;
      logic [RW-1:0]   root_p;
      logic [CW-1:0]   t;
      logic [CW-1:0]   trial;
      if (j == 0) begin : g_first
         assign rad_p  = (2*RW)'(radicand);
         assign rem_p  = '0;
         assign root_p = '0;
      end else begin : g_next
         assign rad_p  = rad_ff[j-1];
         assign rem_p  = rem_ff[j-1];
         assign root_p = root_ff[j-1];
      end
      assign t     = {rem_p[CW-3:0], rad_p[2*(RW-1-j) +: 2]};
      assign trial = {1'b0, root_p, 2'b01};
      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[j] <= rad_p;
            if (t >= trial) begin
               rem_ff[j]  <= t - trial;
               root_ff[j] <= {root_p[RW-2:0], 1'b1};
            end else begin
               rem_ff[j]  <= t;
               root_ff[j] <= {root_p[RW-2:0], 1'b0};
            end
         end
      end
   end

   assign root = root_ff[RW-1];

endmodule

// ===== sv/vap_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module vap_div #(
   parameter int NUM_W = 61,
   parameter int DEN_W = 31,
   parameter int QUO_W = 31
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic [QUO_W-1:0] quot
);
   logic [NUM_W-1:0] num_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [DEN_W-1:0] rem_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];

   for (genvar j = 0; j < QUO_W; j++) begin : g_step
      logic [NUM_W-1:0] num_p;
      logic [DEN_W-1:0] den_p;
      logic [DEN_W-1:0] rem_p;
      logic [QUO_W-1:0] quo_p;
      logic [DEN_W:0]   t;
      if (j == 0) begin : g_first
         assign num_p = numer;
         assign den_p = denom;
         assign rem_p = DEN_W'(numer >> QUO_W);
         assign quo_p = '0;
      end else begin : g_next
         assign num_p = num_ff[j-1];
         assign den_p = den_ff[j-1];
         assign rem_p = rem_ff[j-1];
         assign quo_p = quo_ff[j-1];
      end
      assign t = {rem_p, num_p[QUO_W-1-j]};
      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[j] <= num_p;
            den_ff[j] <= den_p;
            if (t >= {1'b0, den_p}) begin
               rem_ff[j] <= DEN_W'(t - {1'b0, den_p});
               quo_ff[j] <= {quo_p[QUO_W-2:0], 1'b1};
            end else begin
               rem_ff[j] <= DEN_W'(t);
               quo_ff[j] <= {quo_p[QUO_W-2:0], 1'b0};
            end
         end
      end
   end

   assign quot = quo_ff[QUO_W-1];

endmodule

// ===== sv/vertex_angle_3d.sv =====
// vertex angle between two 3d vectors: top level pipeline
// A request enters every cycle while no result is stalled, and then passes through (at the default
// widths: 5 setup stages, a 31-stage length square root, a dividend register, a 31-stage
// divider for the unit vectors, 5 stages for dot product and sine term, a 31-stage sine
// square root, 30 cordic stages and the output register). The whole pipeline holds while
// a result waits on rsp_ready, so no request is lost or repeated.
module vertex_angle_3d #(
   parameter int COORD_BITS      = vap_pkg::COORD_BITS_DEF,
   parameter int ANGLE_FRAC_BITS = vap_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_BITS-1:0]  req_start_x,
   input  logic signed [COORD_BITS-1:0]  req_start_y,
   input  logic signed [COORD_BITS-1:0]  req_start_z,
   input  logic signed [COORD_BITS-1:0]  req_vertex_x,
   input  logic signed [COORD_BITS-1:0]  req_vertex_y,
   input  logic signed [COORD_BITS-1:0]  req_vertex_z,
   input  logic signed [COORD_BITS-1:0]  req_end_x,
   input  logic signed [COORD_BITS-1:0]  req_end_y,
   input  logic signed [COORD_BITS-1:0]  req_end_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [vap_pkg::ANGLE_W-1:0]   rsp_angle,
   output logic                          rsp_degenerate
);
   import vap_pkg::*;

   localparam int DW     = COORD_BITS + 1;
   localparam int MW     = COORD_BITS;
   localparam int LW     = $clog2(MW + 1);
   localparam int SUM_W  = 2 * Q + 2;
   localparam int LEN_W  = (SUM_W + 1) / 2;
   localparam int NUM_W  = 2 * Q + 1;
   localparam int QT_W   = Q + 1;
   localparam int U_W    = QT_W + 1;
   localparam int P_W    = 2 * U_W;
   localparam int C_W    = Q + 2;
   localparam int RAD_W  = 2 * Q + 1;
   localparam int S_W    = (RAD_W + 1) / 2;
   localparam int NST    = 5 + LEN_W + 1 + QT_W + 5 + S_W + Q + 1;
   localparam int RSH    = Q - ANGLE_FRAC_BITS;

   typedef struct packed {
      logic [1:0][2:0]        neg;
      logic [1:0][2:0][Q-1:0] nm;
      logic                   deg;
   } norm_side_type;

   typedef struct packed {
      logic [1:0][2:0] neg;
      logic            deg;
   } div_side_type;

   typedef struct packed {
      logic [Q:0] xabs;
      logic       cn;
      logic       deg;
   } cos_side_type;

   logic en;
   logic [NST-1:0] v_ff;

   assign en        = !v_ff[NST-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = v_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NST-2:0], req_valid};
      end
   end

   // difference vectors
   logic signed [COORD_BITS-1:0] pt [3][3];
   logic signed [DW-1:0]         diff [2][3];
   logic [1:0][2:0][MW-1:0]      mag1_ff;
   logic [1:0][2:0]              neg1_ff;

   always_comb begin
      pt[0][0] = req_start_x;  pt[0][1] = req_start_y;  pt[0][2] = req_start_z;
      pt[1][0] = req_vertex_x; pt[1][1] = req_vertex_y; pt[1][2] = req_vertex_z;
      pt[2][0] = req_end_x;    pt[2][1] = req_end_y;    pt[2][2] = req_end_z;
      for (int i = 0; i < 3; i++) begin
         diff[0][i] = DW'(pt[0][i]) - DW'(pt[1][i]);
         diff[1][i] = DW'(pt[2][i]) - DW'(pt[1][i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int v = 0; v < 2; v++) begin
            for (int i = 0; i < 3; i++) begin
               neg1_ff[v][i] <= diff[v][i][DW-1];
               mag1_ff[v][i] <= diff[v][i][DW-1] ? MW'(-diff[v][i]) : MW'(diff[v][i]);
            end
         end
      end
   end

   // bit length of the largest magnitude
   logic [1:0][2:0][MW-1:0] mag2_ff;
   logic [1:0][2:0]         neg2_ff;
   logic [1:0][LW-1:0]      len2_ff;
   logic [1:0]              zero2_ff;
   logic [MW-1:0]           mx [2];
   logic [LW-1:0]           bl [2];

   always_comb begin
      for (int v = 0; v < 2; v++) begin
         mx[v] = mag1_ff[v][0];
         if (mag1_ff[v][1] > mx[v]) mx[v] = mag1_ff[v][1];
         if (mag1_ff[v][2] > mx[v]) mx[v] = mag1_ff[v][2];
         bl[v] = '0;
         for (int k = 0; k < MW; k++) begin
            if (mx[v][k]) bl[v] = LW'(k + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag2_ff <= mag1_ff;
         neg2_ff <= neg1_ff;
         for (int v = 0; v < 2; v++) begin
            len2_ff[v]  <= bl[v];
            zero2_ff[v] <= (mx[v] == '0);
         end
      end
   end

   // normalize so the largest magnitude sits in [2^29, 2^30)
   logic [1:0][2:0][Q-1:0] nm3_ff;
   logic [1:0][2:0]        neg3_ff;
   logic                   deg3_ff;
   logic [MW+Q-1:0]        wide [2][3];

   always_comb begin
      for (int v = 0; v < 2; v++) begin
         for (int i = 0; i < 3; i++) begin
            wide[v][i] = {mag2_ff[v][i], Q'(0)} >> len2_ff[v];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg3_ff <= neg2_ff;
         deg3_ff <= zero2_ff[0] || zero2_ff[1];
         for (int v = 0; v < 2; v++) begin
            for (int i = 0; i < 3; i++) begin
               nm3_ff[v][i] <= wide[v][i][Q-1:0];
            end
         end
      end
   end

   // squares, then their sum
   logic [1:0][2:0][2*Q-1:0] sq4_ff;
   norm_side_type            side4_ff;
   logic [SUM_W-1:0]         sum5_ff [2];
   norm_side_type            side5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int v = 0; v < 2; v++) begin
            for (int i = 0; i < 3; i++) begin
               sq4_ff[v][i] <= nm3_ff[v][i] * nm3_ff[v][i];
            end
         end
         side4_ff.neg <= neg3_ff;
         side4_ff.nm  <= nm3_ff;
         side4_ff.deg <= deg3_ff;
         for (int v = 0; v < 2; v++) begin
            sum5_ff[v] <= SUM_W'(sq4_ff[v][0]) + SUM_W'(sq4_ff[v][1])
                        + SUM_W'(sq4_ff[v][2]);
         end
         side5_ff <= side4_ff;
      end
   end

   // vector lengths
   logic [LEN_W-1:0] len [2];
   norm_side_type    lside_ff [LEN_W];

   for (genvar v = 0; v < 2; v++) begin : g_len
      vap_sqrt #(.IN_W(SUM_W)) u_len (
         .clock    (clock),
         .en       (en),
         .radicand (sum5_ff[v]),
         .root     (len[v])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lside_ff[0] <= side5_ff;
         for (int k = 1; k < LEN_W; k++) lside_ff[k] <= lside_ff[k-1];
      end
   end

   // dividend with rounding term
   logic [NUM_W-1:0] num_ff [2][3];
   logic [LEN_W-1:0] den_ff [2];
   div_side_type     nside_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int v = 0; v < 2; v++) begin
            den_ff[v] <= len[v];
            for (int i = 0; i < 3; i++) begin
               num_ff[v][i] <= NUM_W'({lside_ff[LEN_W-1].nm[v][i], Q'(0)})
                             + NUM_W'(len[v] >> 1);
            end
         end
         nside_ff.neg <= lside_ff[LEN_W-1].neg;
         nside_ff.deg <= lside_ff[LEN_W-1].deg;
      end
   end

   // unit vector components
   logic [QT_W-1:0] quo [2][3];
   div_side_type    dside_ff [QT_W];

   for (genvar v = 0; v < 2; v++) begin : g_vec
      for (genvar i = 0; i < 3; i++) begin : g_cmp
         vap_div #(.NUM_W(NUM_W), .DEN_W(LEN_W), .QUO_W(QT_W)) u_div (
            .clock (clock),
            .en    (en),
            .numer (num_ff[v][i]),
            .denom (den_ff[v]),
            .quot  (quo[v][i])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dside_ff[0] <= nside_ff;
         for (int k = 1; k < QT_W; k++) dside_ff[k] <= dside_ff[k-1];
      end
   end

   // signed units, products, cosine, cosine squared, sine radicand
   logic signed [U_W-1:0] u_ff [2][3];
   logic                  deg69_ff;
   logic signed [P_W-1:0] p_ff [3];
   logic                  deg70_ff;
   logic signed [C_W-1:0] c_ff;
   logic                  deg71_ff;
   logic signed [P_W-1:0] dsum;
   logic signed [P_W-1:0] dr;
   logic signed [P_W-1:0] one_q;
   logic [RAD_W-1:0]      cc_ff;
   cos_side_type          cs72_ff;
   logic [RAD_W-1:0]      rad_ff;
   cos_side_type          cs73_ff;
   logic signed [P_W-1:0] csq;

   assign one_q = P_W'(1) <<< Q;
   assign dsum  = p_ff[0] + p_ff[1] + p_ff[2];
   assign dr    = (dsum + (one_q >>> 1)) >>> Q;
   assign csq   = P_W'(c_ff) * P_W'(c_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         for (int v = 0; v < 2; v++) begin
            for (int i = 0; i < 3; i++) begin
               u_ff[v][i] <= dside_ff[QT_W-1].neg[v][i] ? -U_W'({1'b0, quo[v][i]})
                                                       :  U_W'({1'b0, quo[v][i]});
            end
         end
         deg69_ff <= dside_ff[QT_W-1].deg;
         for (int i = 0; i < 3; i++) begin
            p_ff[i] <= P_W'(u_ff[0][i]) * P_W'(u_ff[1][i]);
         end
         deg70_ff <= deg69_ff;
         if (dr > one_q) c_ff <= C_W'(one_q);
         else if (dr < -one_q) c_ff <= C_W'(-one_q);
         else c_ff <= C_W'(dr);
         deg71_ff <= deg70_ff;
         cc_ff        <= csq[RAD_W-1:0];
         cs72_ff.xabs <= c_ff[C_W-1] ? (Q+1)'(-c_ff) : (Q+1)'(c_ff);
         cs72_ff.cn   <= c_ff[C_W-1];
         cs72_ff.deg  <= deg71_ff;
         rad_ff  <= (RAD_W'(1) << (2*Q)) - cc_ff;
         cs73_ff <= cs72_ff;
      end
   end

   // sine term
   logic [S_W-1:0] sine;
   cos_side_type   sside_ff [S_W];

   vap_sqrt #(.IN_W(RAD_W)) u_sine (
      .clock    (clock),
      .en       (en),
      .radicand (rad_ff),
      .root     (sine)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         sside_ff[0] <= cs73_ff;
         for (int k = 1; k < S_W; k++) sside_ff[k] <= sside_ff[k-1];
      end
   end

   // cordic vectoring
   logic signed [CORDIC_W-1:0] x_ff [Q];
   logic signed [CORDIC_W-1:0] y_ff [Q];
   logic signed [CORDIC_W-1:0] z_ff [Q];
   logic [1:0]                 fl_ff [Q];

   for (genvar i = 0; i < Q; i++) begin : g_cordic
      logic signed [CORDIC_W-1:0] xp, yp, zp, xs, ys;
      logic [1:0]                 flp;
      if (i == 0) begin : g_first
         assign xp  = CORDIC_W'(sside_ff[S_W-1].xabs);
         assign yp  = CORDIC_W'(sine);
         assign zp  = '0;
         assign flp = {sside_ff[S_W-1].cn, sside_ff[S_W-1].deg};
      end else begin : g_next
         assign xp  = x_ff[i-1];
         assign yp  = y_ff[i-1];
         assign zp  = z_ff[i-1];
         assign flp = fl_ff[i-1];
      end
      assign xs = xp >>> i;
      assign ys = yp >>> i;
      always_ff @(posedge clock) begin
         if (en) begin
            fl_ff[i] <= flp;
            if (yp > 0) begin
               x_ff[i] <= xp + ys;
               y_ff[i] <= yp - xs;
               z_ff[i] <= zp + atan_q30(i);
            end else begin
               x_ff[i] <= xp - ys;
               y_ff[i] <= yp + xs;
               z_ff[i] <= zp - atan_q30(i);
            end
         end
      end
   end

   // clamp, fold and round
   logic signed [CORDIC_W-1:0] zc, ang, ang_r;
   logic [ANGLE_W-1:0]         angle_ff;
   logic                       deg_ff;

   always_comb begin
      zc = z_ff[Q-1];
      if (zc < 0) zc = '0;
      if (zc > HALF_PI_Q30) zc = HALF_PI_Q30;
      ang   = fl_ff[Q-1][1] ? PI_Q30 - zc : zc;
      ang_r = (ang + (CORDIC_W'(1) <<< (RSH - 1))) >>> RSH;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         deg_ff   <= fl_ff[Q-1][0];
         angle_ff <= fl_ff[Q-1][0] ? '0 : ang_r[ANGLE_W-1:0];
      end
   end

   assign rsp_angle      = angle_ff;
   assign rsp_degenerate = deg_ff;

endmodule

// ===== sv/vap_checker.sv =====
// port checker for the vertex angle block, bound to the top level
module vap_checker #(
   parameter int ANGLE_FRAC_BITS = vap_pkg::ANGLE_FRAC_BITS_DEF
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [vap_pkg::ANGLE_W-1:0] rsp_angle,
   input logic                        rsp_degenerate
);
   import vap_pkg::*;

   localparam int RSH = Q - ANGLE_FRAC_BITS;
   localparam logic [CORDIC_W-1:0] PI_R = (PI_Q30 + (CORDIC_W'(1) << (RSH - 1))) >> RSH;

   // held result keeps its value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_angle) && $stable(rsp_degenerate))
      else $error("result changed while stalled");

   // degenerate request carries a zero angle
   a_deg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_angle == '0)
      else $error("degenerate result with nonzero angle");

   // angle never exceeds pi
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (PI_R < (CORDIC_W'(1) << ANGLE_W)) |-> CORDIC_W'(rsp_angle) <= PI_R)
      else $error("angle above pi");

   // a stalled result stalls the request side
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while pipeline stalled");

   // nothing comes out right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind vertex_angle_3d vap_checker #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_vap_checker (.*);

// ===== verif/tb_vertex_angle_3d.sv =====
// testbench for vertex_angle_3d: random and directed point triples checked against a predictor
module tb_vertex_angle_3d;
   import vap_pkg::*;

   localparam int CB = COORD_BITS_DEF;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      logic [ANGLE_W-1:0] angle;
      logic               degenerate;
   } angle_rsp_type;

   typedef logic signed [CB-1:0] coord_type;

   class angle_scoreboard_type;
      angle_rsp_type pending[$];
      int            errors;
      int            checked;
      int            degen_seen;

      function automatic longint unsigned root64(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      // unit vector in q30, returns 0 for a zero vector
      function automatic bit unit_q30(input longint d[3], output longint u[3]);
         longint unsigned m[3], mx, sum, len, q;
         int l;
         mx = 0;
         sum = 0;
         for (int i = 0; i < 3; i++) begin
            m[i] = d[i] < 0 ? -d[i] : d[i];
            if (m[i] > mx) mx = m[i];
         end
         if (mx == 0) return 0;
         l = 0;
         while (l < 63 && (mx >> l) != 0) l++;
         for (int i = 0; i < 3; i++) begin
            if (l < Q) m[i] = m[i] << (Q - l);
            else m[i] = m[i] >> (l - Q);
            sum += m[i] * m[i];
         end
         len = root64(sum);
         for (int i = 0; i < 3; i++) begin
            q = ((m[i] << Q) + (len >> 1)) / len;
            u[i] = d[i] < 0 ? -longint'(q) : longint'(q);
         end
         return 1;
      endfunction

      function automatic angle_rsp_type vertex_angle(coord_type p[9]);
         angle_rsp_type r;
         longint a[3], b[3], ua[3], ub[3];
         longint dot, c, x, y, z, t, xs, ys, ang;
         for (int i = 0; i < 3; i++) begin
            a[i] = longint'(p[i]) - longint'(p[3+i]);
            b[i] = longint'(p[6+i]) - longint'(p[3+i]);
         end
         if (!unit_q30(a, ua) || !unit_q30(b, ub)) begin
            r.angle = '0;
            r.degenerate = 1'b1;
            return r;
         end
         dot = 0;
         for (int i = 0; i < 3; i++) dot += ua[i] * ub[i];
         c = (dot + (64'sd1 <<< (Q - 1))) >>> Q;
         if (c > (64'sd1 <<< Q)) c = 64'sd1 <<< Q;
         if (c < -(64'sd1 <<< Q)) c = -(64'sd1 <<< Q);
         y = longint'(root64((64'd1 << 60) - longint'(c * c)));
         x = c < 0 ? -c : c;
         z = 0;
         for (int i = 0; i < 30; i++) begin
            t = longint'(atan_q30(i));
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
               x += ys;
               y -= xs;
               z += t;
            end else begin
               x -= ys;
               y += xs;
               z -= t;
            end
         end
         if (z < 0) z = 0;
         if (z > longint'(HALF_PI_Q30)) z = longint'(HALF_PI_Q30);
         ang = c < 0 ? longint'(PI_Q30) - z : z;
         ang = (ang + (64'sd1 <<< (Q - ANGLE_FRAC_BITS_DEF - 1))) >>> (Q - ANGLE_FRAC_BITS_DEF);
         r.angle = ang[ANGLE_W-1:0];
         r.degenerate = 1'b0;
         return r;
      endfunction

      function void note_request(coord_type p[9]);
         pending.push_back(vertex_angle(p));
      endfunction

      function void check_result(logic [ANGLE_W-1:0] angle, logic degenerate);
         angle_rsp_type e;
         checked++;
         if (degenerate) degen_seen++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result angle=%0d degenerate=%0b",
                     $time, angle, degenerate);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (angle !== e.angle) begin
            $display("%0t: angle mismatch expected %0d actual %0d", $time, e.angle, angle);
            errors++;
         end
         if (degenerate !== e.degenerate) begin
            $display("%0t: degenerate mismatch expected %0b actual %0b",
                     $time, e.degenerate, degenerate);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   coord_type req_pt[9] = '{default: '0};
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [ANGLE_W-1:0] rsp_angle;
   logic rsp_degenerate;

   angle_scoreboard_type sb = new();
   int  idle_cycles = 0;
   bit  sending_done = 1'b0;
   bit  calm_phase;
   int  sent;

   always #6 clock = ~clock;

   vertex_angle_3d i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_start_x(req_pt[0]), .req_start_y(req_pt[1]), .req_start_z(req_pt[2]),
      .req_vertex_x(req_pt[3]), .req_vertex_y(req_pt[4]), .req_vertex_z(req_pt[5]),
      .req_end_x(req_pt[6]), .req_end_y(req_pt[7]), .req_end_z(req_pt[8]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_angle(rsp_angle), .rsp_degenerate(rsp_degenerate)
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_angle, rsp_degenerate);
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   // receiver stalls
   initial begin
      int w;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         w = calm_phase ? 0 : $urandom_range(0, 13);
         if (w > 0) begin
            rsp_ready <= 1'b0;
            repeat (w) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_points(coord_type p[9], int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      for (int i = 0; i < 9; i++) req_pt[i] <= p[i];
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(p);
      sent++;
      @(negedge clock);
   endtask

   function automatic coord_type rand_coord(int mode);
      case (mode)
         0: return coord_type'($urandom);
         1: return coord_type'($urandom_range(0, 512) - 256);
         2: return coord_type'($urandom_range(0, 8) - 4);
         default: return $urandom_range(0, 1) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}};
      endcase
   endfunction

   task automatic send_directed();
      coord_type p[9];
      coord_type mx, mn;
      mx = {1'b0, {(CB-1){1'b1}}};
      mn = {1'b1, {(CB-1){1'b0}}};
      // zero vectors
      p = '{default: 0};
      send_points(p, 0);
      p = '{1, 2, 3, 1, 2, 3, 4, 5, 6};
      send_points(p, 0);
      p = '{4, 5, 6, 1, 2, 3, 1, 2, 3};
      send_points(p, 1);
      // parallel, opposite, right angle
      p = '{256, 0, 0, 0, 0, 0, 512, 0, 0};
      send_points(p, 0);
      p = '{256, 0, 0, 0, 0, 0, -512, 0, 0};
      send_points(p, 0);
      p = '{0, 256, 0, 0, 0, 0, 0, 0, 256};
      send_points(p, 0);
      p = '{1, 1, 1, 0, 0, 0, 1, 1, 1};
      send_points(p, 0);
      p = '{-1, -1, -1, 0, 0, 0, 1, 1, 1};
      send_points(p, 0);
      // extremes
      p = '{mx, mx, mx, mn, mn, mn, mn, mn, mx};
      send_points(p, 0);
      p = '{mn, mn, mn, mx, mx, mx, mn, mx, mn};
      send_points(p, 0);
      p = '{mx, mn, mx, mn, mx, mn, mx, mn, mx};
      send_points(p, 2);
      p = '{mx, 0, 0, mn, 0, 0, mn, 0, 1};
      send_points(p, 0);
      p = '{mx, mx, mx, 0, 0, 0, mn, mn, mn};
      send_points(p, 0);
      p = '{-1, -1, -1, -1, -1, -1, 0, 0, 0};
      send_points(p, 0);
      p = '{1, 0, 0, 0, 0, 0, mx, 1, 0};
      send_points(p, 0);
   endtask

   initial begin
      coord_type p[9];
      int mode;
      int pulses;
      sent = 0;
      calm_phase = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_directed();
      for (int n = 0; n < 900; n++) begin
         calm_phase = (n / 150) % 3 == 1;
         mode = $urandom_range(0, 3);
         for (int i = 0; i < 9; i++) p[i] = rand_coord(mode == 3 ? $urandom_range(0, 3) : mode);
         // occasional coincident points
         if ($urandom_range(0, 15) == 0) for (int i = 0; i < 3; i++) p[i] = p[3+i];
         if ($urandom_range(0, 15) == 0) for (int i = 0; i < 3; i++) p[6+i] = p[3+i];
         // collinear cases push the cosine to its limits
         if ($urandom_range(0, 11) == 0) begin
            pulses = $urandom_range(0, 1) ? 2 : -2;
            for (int i = 0; i < 3; i++) begin
               p[3+i] = rand_coord(1);
               p[i] = p[3+i] + rand_coord(2);
               p[6+i] = coord_type'(p[3+i] + (p[i] - p[3+i]) * pulses);
            end
         end
         send_points(p, calm_phase ? 0 : $urandom_range(0, 13));
      end
      req_valid <= 1'b0;
      sending_done = 1'b1;
   end

   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout with %0d results outstanding", sb.pending.size());
            $display("CHECKS FAILED");
            $finish;
         end
         if (sending_done && sb.pending.size() == 0) begin
            repeat (200) @(posedge clock);
            $display("sent %0d point triples, checked %0d results (%0d degenerate)",
                     sent, sb.checked, sb.degen_seen);
            if (sb.errors == 0 && sb.pending.size() == 0) begin
               $display("ALL CHECKS PASSED");
            end else begin
               $display("CHECKS FAILED");
            end
            $finish;
         end
      end
   end

endmodule

// ===== filelist.f =====
sv/vap_pkg.sv
sv/vap_sqrt.sv
sv/vap_div.sv
sv/vertex_angle_3d.sv
sv/vap_checker.sv
verif/tb_vertex_angle_3d.sv
